// ===== design/gpoc_pkg.sv =====
// Package for the gap-constrained pattern occurrence counter.
// Register indexes, port widths, parameter defaults and control structs.
// No dependencies.
package gpoc_pkg;

    localparam int DEF_MAX_PATTERN = 8;
    localparam int DEF_MAX_GAP     = 15;
    localparam int DEF_COUNT_WIDTH = 48;

    localparam int SYM_W       = 8;
    localparam int PATTERN_W   = 64;
    localparam int PATTERN_SYMS = PATTERN_W / SYM_W;
    localparam int LEN_W       = 4;
    localparam int GAP_W       = 4;
    localparam int OUT_W       = 48;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_SYMBOLS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP         = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP         = 8'd3;

    localparam logic [LEN_W-1:0] LEN_RESET = 4'd2;
    localparam logic [LEN_W-1:0] LEN_MIN   = 4'd2;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic shift;
        logic clear;
        logic empty;
        logic add_fresh;
    } t_row_ctrl;

endpackage

// ===== design/gap_pattern_occurrence_counter_core.sv =====
// Gap-constrained pattern occurrence counter, top level.
// Result is registered and valid in the cycle after the input transfer; throughput 1 item per cycle
// when not stalled, set by the per-row window-sum register feeding the next row's cells.
// Input stalls in the cycle after each configuration write while the window sums refresh.
// Synchronous active-low reset clears history, total, flag and registers (0, 2, 0, 0).
// Depends on gpoc_pkg, gpoc_row, gpoc_cell.
module gap_pattern_occurrence_counter_core #(
    parameter int MAX_PATTERN = gpoc_pkg::DEF_MAX_PATTERN,
    parameter int MAX_GAP     = gpoc_pkg::DEF_MAX_GAP,
    parameter int COUNT_WIDTH = gpoc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [gpoc_pkg::SYM_W-1:0]       i_symbol,
    input  logic                             i_end_of_sequence,
    input  logic                             i_clear_total,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [gpoc_pkg::OUT_W-1:0]       o_ends_here,
    output logic [gpoc_pkg::OUT_W-1:0]       o_running_total,
    output logic                             o_saturated,
    output logic                             o_sequence_done,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gpoc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [gpoc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ROWS      = MAX_PATTERN - 1;
    localparam int DEPTH     = MAX_GAP + 1;
    localparam int GW        = $clog2(DEPTH + 1);
    localparam int CMPW      = (GW > gpoc_pkg::GAP_W) ? GW : gpoc_pkg::GAP_W;
    localparam int QW        = COUNT_WIDTH + $clog2(DEPTH);
    localparam int SYM_LIMIT = (MAX_PATTERN < gpoc_pkg::PATTERN_SYMS) ?
                               MAX_PATTERN : gpoc_pkg::PATTERN_SYMS;
    localparam int WIDE_W    = 64;

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // configuration
    logic [gpoc_pkg::PATTERN_W-1:0] r_pattern;
    logic [gpoc_pkg::LEN_W-1:0]     r_len;
    logic [gpoc_pkg::GAP_W-1:0]     r_min_gap;
    logic [gpoc_pkg::GAP_W-1:0]     r_max_gap;
    logic                           r_cfg_dirty;
    logic                           cfg_write;

    // datapath
    logic                           accept;
    logic [gpoc_pkg::LEN_W-1:0]     len_c;
    logic [CMPW-1:0]                hi_c;
    logic [CMPW-1:0]                lo_c;
    logic                           win_empty;
    logic [DEPTH-1:0]               sel_x;
    logic [DEPTH-1:0]               sel_y;
    gpoc_pkg::t_row_ctrl            row_ctrl;

    logic [QW-1:0]                  win_raw [ROWS];
    logic [COUNT_WIDTH-1:0]         win_sat [ROWS];
    logic [ROWS-1:0]                win_ovf;
    logic [COUNT_WIDTH-1:0]         fresh   [ROWS];
    logic [ROWS-1:0]                row_match;

    logic [gpoc_pkg::SYM_W-1:0]     last_sym;
    logic                           last_match;
    logic [COUNT_WIDTH-1:0]         ends_sel;
    logic                           ends_ovf_sel;
    logic [COUNT_WIDTH-1:0]         ends;
    logic                           fresh_ovf;
    logic [COUNT_WIDTH-1:0]         total_base;
    logic [COUNT_WIDTH:0]           total_sum;
    logic                           total_ovf;
    logic                           sat_any;

    logic [COUNT_WIDTH-1:0]         r_total;
    logic [COUNT_WIDTH-1:0]         n_total;
    logic                           r_flag;
    logic                           n_flag;
    logic                           r_out_valid;
    logic [COUNT_WIDTH-1:0]         r_ends;
    logic                           r_eos;
    logic [WIDE_W-1:0]              ends_wide;
    logic [WIDE_W-1:0]              total_wide;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= '0;
            r_len       <= gpoc_pkg::LEN_RESET;
            r_min_gap   <= '0;
            r_max_gap   <= '0;
            r_cfg_dirty <= 1'b0;
        end else begin
            r_cfg_dirty <= cfg_write;
            if (cfg_write) begin
                unique case (i_cfg_index)
                    gpoc_pkg::CFG_PATTERN_SYMBOLS: begin
                        r_pattern <= i_cfg_data;
                    end
                    gpoc_pkg::CFG_PATTERN_LENGTH: begin
                        r_len <= i_cfg_data[gpoc_pkg::LEN_W-1:0];
                    end
                    gpoc_pkg::CFG_MIN_GAP: begin
                        r_min_gap <= i_cfg_data[gpoc_pkg::GAP_W-1:0];
                    end
                    gpoc_pkg::CFG_MAX_GAP: begin
                        r_max_gap <= i_cfg_data[gpoc_pkg::GAP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // handshake
    assign o_stall = (r_out_valid && i_stall) || r_cfg_dirty;
    assign accept  = i_valid && !o_stall;

    // clamped configuration
    always_comb begin
        priority if (r_len < gpoc_pkg::LEN_MIN) begin
            len_c = gpoc_pkg::LEN_MIN;
        end else if (int'(r_len) > SYM_LIMIT) begin
            len_c = gpoc_pkg::LEN_W'(SYM_LIMIT);
        end else begin
            len_c = r_len;
        end
        if (int'(r_max_gap) > MAX_GAP) begin
            hi_c = CMPW'(MAX_GAP);
        end else begin
            hi_c = CMPW'(r_max_gap);
        end
        lo_c      = CMPW'(r_min_gap);
        win_empty = lo_c > hi_c;
    end

    // tap selects: after a shift the window moves one place back
    always_comb begin
        for (int d = 0; d < DEPTH; d++) begin
            if (accept) begin
                sel_x[d] = (d + 1 == int'(hi_c));
                sel_y[d] = (d + 2 == int'(lo_c));
            end else begin
                sel_x[d] = (d == int'(hi_c));
                sel_y[d] = (d + 1 == int'(lo_c));
            end
        end
    end

    assign row_ctrl.shift     = accept;
    assign row_ctrl.clear     = accept && i_end_of_sequence;
    assign row_ctrl.empty     = win_empty;
    assign row_ctrl.add_fresh = accept && (lo_c == '0);

    for (genvar j = 0; j < ROWS; j++) begin : g_row
        assign row_match[j] =
            (i_symbol == r_pattern[gpoc_pkg::SYM_W*(j % gpoc_pkg::PATTERN_SYMS) +:
                                   gpoc_pkg::SYM_W])
            && (j + 1 < int'(len_c));

        assign win_ovf[j] = |win_raw[j][QW-1:COUNT_WIDTH];
        assign win_sat[j] = win_ovf[j] ? CMAX : win_raw[j][COUNT_WIDTH-1:0];

        if (j == 0) begin : g_first
            assign fresh[j] = row_match[j] ? COUNT_WIDTH'(1) : '0;
        end else begin : g_next
            assign fresh[j] = row_match[j] ? win_sat[j-1] : '0;
        end

        gpoc_row #(
            .DEPTH (DEPTH),
            .CW    (COUNT_WIDTH),
            .QW    (QW)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (row_ctrl),
            .i_fresh (fresh[j]),
            .i_sel_x (sel_x),
            .i_sel_y (sel_y),
            .o_win   (win_raw[j])
        );
    end

    // occurrences ending here and overflow tracking
    always_comb begin
        last_sym     = '0;
        ends_sel     = '0;
        ends_ovf_sel = 1'b0;
        fresh_ovf    = 1'b0;
        for (int k = 0; k < gpoc_pkg::PATTERN_SYMS; k++) begin
            if (k + 1 == int'(len_c)) begin
                last_sym = r_pattern[gpoc_pkg::SYM_W*k +: gpoc_pkg::SYM_W];
            end
        end
        for (int j = 0; j < ROWS; j++) begin
            if (j + 2 == int'(len_c)) begin
                ends_sel     = win_sat[j];
                ends_ovf_sel = win_ovf[j];
            end
            if (j > 0 && row_match[j] && win_ovf[(j > 0) ? j-1 : 0]) begin
                fresh_ovf = 1'b1;
            end
        end
        last_match = (i_symbol == last_sym);
        ends       = last_match ? ends_sel : '0;

        total_base = i_clear_total ? '0 : r_total;
        total_sum  = {1'b0, total_base} + {1'b0, ends};
        total_ovf  = total_sum[COUNT_WIDTH];
        n_total    = total_ovf ? CMAX : total_sum[COUNT_WIDTH-1:0];
        sat_any    = fresh_ovf || (last_match && ends_ovf_sel) || total_ovf;
        n_flag     = (i_clear_total ? 1'b0 : r_flag) || sat_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_total     <= n_total;
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ends <= ends;
            r_eos  <= i_end_of_sequence;
        end
    end

    assign ends_wide  = WIDE_W'(r_ends);
    assign total_wide = WIDE_W'(r_total);

    assign o_valid         = r_out_valid;
    assign o_ends_here     = ends_wide[gpoc_pkg::OUT_W-1:0];
    assign o_running_total = total_wide[gpoc_pkg::OUT_W-1:0];
    assign o_saturated     = r_flag;
    assign o_sequence_done = r_eos;

endmodule

// ===== design/gpoc_cell.sv =====
// One history cell: prefix sum of partial-match counts up to its age.
// Takes the neighbour's prefix sum each transfer. Depends on gpoc_pkg.
module gpoc_cell #(
    parameter int CW = gpoc_pkg::DEF_COUNT_WIDTH,
    parameter int QW = gpoc_pkg::DEF_COUNT_WIDTH + 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gpoc_pkg::t_cell_ctrl  i_ctrl,
    input  logic [QW-1:0]         i_prev,
    input  logic [CW-1:0]         i_fresh,
    output logic [QW-1:0]         o_q
);

    logic [QW-1:0] r_q;
    logic [QW-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctrl.clear) begin
            n_q = '0;
        end else if (i_ctrl.shift) begin
            n_q = i_prev + QW'(i_fresh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== design/gpoc_row.sv =====
// One pattern prefix: chain of history cells plus the registered window sum.
// Window sum is the difference of two selected prefix sums. Depends on gpoc_pkg, gpoc_cell.
module gpoc_row #(
    parameter int DEPTH = gpoc_pkg::DEF_MAX_GAP + 1,
    parameter int CW    = gpoc_pkg::DEF_COUNT_WIDTH,
    parameter int QW    = gpoc_pkg::DEF_COUNT_WIDTH + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gpoc_pkg::t_row_ctrl  i_ctrl,
    input  logic [CW-1:0]        i_fresh,
    input  logic [DEPTH-1:0]     i_sel_x,
    input  logic [DEPTH-1:0]     i_sel_y,
    output logic [QW-1:0]        o_win
);

    logic [QW-1:0]        q [DEPTH];
    gpoc_pkg::t_cell_ctrl cell_ctrl;
    logic [QW-1:0]        sum_x;
    logic [QW-1:0]        sum_y;
    logic [QW-1:0]        r_win;
    logic [QW-1:0]        n_win;

    assign cell_ctrl.shift = i_ctrl.shift;
    assign cell_ctrl.clear = i_ctrl.clear;

    for (genvar d = 0; d < DEPTH; d++) begin : g_cell
        gpoc_cell #(
            .CW (CW),
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_prev  ((d == 0) ? '0 : q[(d == 0) ? 0 : d-1]),
            .i_fresh (i_fresh),
            .o_q     (q[d])
        );
    end

    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int d = 0; d < DEPTH; d++) begin
            sum_x = sum_x | (i_sel_x[d] ? q[d] : '0);
            sum_y = sum_y | (i_sel_y[d] ? q[d] : '0);
        end
        if (i_ctrl.clear || i_ctrl.empty) begin
            n_win = '0;
        end else begin
            n_win = sum_x - sum_y + (i_ctrl.add_fresh ? QW'(i_fresh) : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule
